/* rtl/nnt_pkg.sv */
// Shared types and constants for the nearest-neighbor tour builder.
// No dependencies; used by nnt_cost_mem and nearest_neighbour_tour.
package nnt_pkg;

  localparam int NODE_W  = 6;   // node index width, matrix side is 2**NODE_W
  localparam int CNT_W   = 7;   // node count width, holds 2**NODE_W itself
  localparam int COST_W  = 32;
  localparam int TOTAL_W = 38;

  localparam logic [COST_W-1:0]  COST_INF  = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_INF = '1;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_BUILD = 1'b1;

  typedef struct packed {
    logic              command;
    logic [NODE_W-1:0] row;
    logic [NODE_W-1:0] col;
    logic [COST_W-1:0] cost_value;
    logic [NODE_W-1:0] start_node;
  } item_t;

  typedef struct packed {
    logic [NODE_W-1:0]  node;
    logic [NODE_W-1:0]  next_node;
    logic [TOTAL_W-1:0] tour_cost;
    logic               new_best;
    logic               last;
  } result_t;

endpackage

/* rtl/nnt_cost_mem.sv */
// Cost matrix storage: one write port, one read port with registered data.
// Depends on nnt_pkg for the cost width.
module nnt_cost_mem #(
  parameter int ADDR_W = 12,
  parameter int DEPTH  = 4096
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic [nnt_pkg::COST_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [ADDR_W-1:0]         rd_addr,
  output logic [nnt_pkg::COST_W-1:0] rd_data
);

  logic [nnt_pkg::COST_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/nearest_neighbour_tour.sv */
// Nearest-neighbor tour builder: top level with control sequencer.
// Depends on nnt_pkg (types, constants) and nnt_cost_mem (cost matrix).
//
// Usage: the item channel (item_valid / item_stall / item) carries two
// commands. A load writes one cost entry and yields no result. A build
// starts at item.start_node and yields one result per node on the result
// channel (result_valid / result_stall / result), in visiting order; the
// final one (last = 1) is the edge back to the start and carries the tour
// cost and the new_best flag. A build whose start node is not below the
// node count is dropped without results.
// Each of the N-1 steps reads one matrix row from the cost memory, one entry
// per cycle, and then emits its result; the closing edge reads one more
// entry (states CLOSE, CLOSE_WAIT) and then the build returns to idle. A build
// is bounded by the single read port of the cost memory. One item is worked
// on at a time; item_stall is high while a build runs. The user must write
// num_nodes through cfg_write / cfg_data only while idle; the block does not
// enforce this. Values below 2 act as 2, above MAX_NODES as MAX_NODES.
// Reset clears the visited marks, the best-tour record and the output valid
// flag and sets num_nodes to 64; the cost matrix is not cleared. A stall
// on the result side holds the current result; the build waits to emit.
module nearest_neighbour_tour #(
  parameter int MAX_NODES = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  nnt_pkg::item_t         item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output nnt_pkg::result_t       result,
  input  logic                   cfg_write,
  input  logic [nnt_pkg::CNT_W-1:0] cfg_data
);

  localparam int ROW_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int ADDR_W = ROW_W + nnt_pkg::NODE_W;
  localparam int DEPTH  = MAX_NODES * (2 ** nnt_pkg::NODE_W);

  typedef enum logic [2:0] {
    IDLE, SCAN, EMIT, CLOSE, CLOSE_WAIT
  } state_t;

  state_t state;

  logic [nnt_pkg::CNT_W-1:0]   num_nodes;
  logic [nnt_pkg::CNT_W-1:0]   n_eff;
  logic [MAX_NODES-1:0]        visited;
  logic [nnt_pkg::NODE_W-1:0]  cur;
  logic [nnt_pkg::NODE_W-1:0]  start;
  logic [nnt_pkg::CNT_W-1:0]   idx;
  logic [nnt_pkg::CNT_W-1:0]   step;
  logic                        s1_valid;
  logic                        s1_skip;
  logic [nnt_pkg::NODE_W-1:0]  s1_idx;
  logic                        found;
  logic [nnt_pkg::NODE_W-1:0]  pick;
  logic [nnt_pkg::COST_W-1:0]  pick_cost;
  logic [nnt_pkg::TOTAL_W-1:0] total;
  logic                        inf;
  logic [nnt_pkg::TOTAL_W-1:0] best_cost;
  logic                        best_valid;

  logic                        accept;
  logic                        out_room;
  logic                        emit;
  logic                        wr_en;
  logic [ADDR_W-1:0]           wr_addr;
  logic                        rd_en;
  logic [ADDR_W-1:0]           rd_addr;
  logic [nnt_pkg::COST_W-1:0]  rd_data;
  logic [nnt_pkg::TOTAL_W-1:0] final_total;
  logic                        better;

  always_comb begin
    if (num_nodes < nnt_pkg::CNT_W'(2)) begin
      n_eff = nnt_pkg::CNT_W'(2);
    end else if (num_nodes > nnt_pkg::CNT_W'(MAX_NODES)) begin
      n_eff = nnt_pkg::CNT_W'(MAX_NODES);
    end else begin
      n_eff = num_nodes;
    end
  end

  assign item_stall = (state != IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_room   = !result_valid || !result_stall;
  assign emit       = out_room && ((state == EMIT) || (state == CLOSE_WAIT));

  // loads outside the stored rows can never be read back
  assign wr_en   = accept && (item.command == nnt_pkg::CMD_LOAD) &&
                   ({1'b0, item.row} < nnt_pkg::CNT_W'(MAX_NODES));
  assign wr_addr = {item.row[ROW_W-1:0], item.col};

  assign rd_en   = ((state == SCAN) && (idx < n_eff)) || (state == CLOSE);
  assign rd_addr = (state == CLOSE) ? {cur[ROW_W-1:0], start}
                                    : {cur[ROW_W-1:0], idx[nnt_pkg::NODE_W-1:0]};

  nnt_cost_mem #(
    .ADDR_W (ADDR_W),
    .DEPTH  (DEPTH)
  ) u_cost_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (item.cost_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // closing edge: any infinite edge saturates the total
  always_comb begin
    if (inf || (rd_data == nnt_pkg::COST_INF)) begin
      final_total = nnt_pkg::TOTAL_INF;
    end else begin
      final_total = total + nnt_pkg::TOTAL_W'(rd_data);
    end
    better = !best_valid || (final_total < best_cost);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      num_nodes    <= nnt_pkg::CNT_W'(64);
      visited      <= '0;
      best_cost    <= '0;
      best_valid   <= 1'b0;
      result_valid <= 1'b0;
      s1_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        num_nodes <= cfg_data;
      end
      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      // compare stage for the read issued last cycle
      if (s1_valid && !s1_skip && (!found || (rd_data < pick_cost))) begin
        found     <= 1'b1;
        pick      <= s1_idx;
        pick_cost <= rd_data;
      end

      unique case (state)
        IDLE: begin
          s1_valid <= 1'b0;
          if (accept && (item.command == nnt_pkg::CMD_BUILD) &&
              ({1'b0, item.start_node} < n_eff)) begin
            visited <= MAX_NODES'(1) << item.start_node[ROW_W-1:0];
            cur   <= item.start_node;
            start <= item.start_node;
            idx   <= '0;
            step  <= '0;
            found <= 1'b0;
            total <= '0;
            inf   <= 1'b0;
            state <= SCAN;
          end
        end
        SCAN: begin
          if (idx < n_eff) begin
            s1_valid <= 1'b1;
            s1_idx   <= idx[nnt_pkg::NODE_W-1:0];
            s1_skip  <= visited[idx[ROW_W-1:0]];
            idx      <= idx + 1'b1;
          end else begin
            s1_valid <= 1'b0;
            state    <= EMIT;
          end
        end
        EMIT: begin
          if (out_room) begin
            result.node      <= cur;
            result.next_node <= pick;
            result.tour_cost <= '0;
            result.new_best  <= 1'b0;
            result.last      <= 1'b0;
            total            <= total + nnt_pkg::TOTAL_W'(pick_cost);
            if (pick_cost == nnt_pkg::COST_INF) begin
              inf <= 1'b1;
            end
            visited[pick[ROW_W-1:0]] <= 1'b1;
            cur   <= pick;
            step  <= step + 1'b1;
            idx   <= '0;
            found <= 1'b0;
            if (step == n_eff - nnt_pkg::CNT_W'(2)) begin
              state <= CLOSE;
            end else begin
              state <= SCAN;
            end
          end
        end
        CLOSE: begin
          state <= CLOSE_WAIT;
        end
        CLOSE_WAIT: begin
          if (out_room) begin
            result.node      <= cur;
            result.next_node <= start;
            result.tour_cost <= final_total;
            result.new_best  <= better;
            result.last      <= 1'b1;
            if (better) begin
              best_cost  <= final_total;
              best_valid <= 1'b1;
            end
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
